[design/fpq_alu_pkg.sv]
// ----------------------------------------------------------------------------
// fpq_alu_pkg: shared types for the Q24.8 fixed-point ALU
// Action and status codes and the request and response beat layouts.
// ----------------------------------------------------------------------------
package fpq_alu_pkg;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_GT       = 4'd4,
    ACT_LT       = 4'd5,
    ACT_GE       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef enum logic {
    CFG_LOW_LIMIT  = 1'b0,
    CFG_HIGH_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    status_e            status;
  } rsp_t;

endpackage

[design/fixed_point_q24_8_alu_core.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core: pipelined signed fixed-point ALU
// Add, subtract, increment, decrement, multiply, divide, compare, min/max and integer conversion.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (action, operand_a, operand_b) enter on in_valid_i/in_ready_o
//   and one response beat (result_value, compare_true, status) leaves on
//   out_valid_o/out_ready_i for each request, in order.
//   The limits for integer-to-fixed conversion are written on cfg_we_i with
//   cfg_idx_i selecting the low (0) or high (1) limit; write only while idle.
// Pipeline and throughput:
//   Every action takes the same path: one prepare stage, ceil((32+FRAC_BITS)/4)
//   divide stages of four restoring quotient bits each, and one output stage.
//   One beat is accepted per cycle unless the output stalls; the 32x32 multiply
//   sits in the prepare stage and the divider is fully pipelined.
// Reset:
//   rst_ni clears all stage valid bits and loads the default conversion limits.
// Backpressure:
//   Each stage holds while the next one is full and stalled; bubbles close up,
//   so the block keeps taking beats until every stage holds an item.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpq_alu_pkg::req_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fpq_alu_pkg::rsp_t   out_data_o,
  input  logic                cfg_we_i,
  input  fpq_alu_pkg::cfg_idx_e cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);

  localparam int DW     = 32 + FRAC_BITS;
  localparam int BPS    = 4;
  localparam int NDIV   = (DW + BPS - 1) / BPS;
  localparam int NSTG   = NDIV + 2;

  typedef struct packed {
    fpq_alu_pkg::action_e action;
    logic [32:0]          rem;
    logic [DW-1:0]        quo;
    logic [31:0]          dvs;
    logic                 neg;
    logic [31:0]          res;
    logic                 cmp;
    fpq_alu_pkg::status_e status;
  } stg_t;

  logic signed [31:0] low_lim_q;
  logic [30:0]        high_lim_q;

  logic [NSTG-1:0]    vld_q;
  logic [NSTG:0]      rdy;
  stg_t               stg_q [NSTG];
  stg_t               stg_d [NSTG];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_lim_q  <= -32'sd8388608;
      high_lim_q <= 31'd8388607;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpq_alu_pkg::CFG_LOW_LIMIT:  low_lim_q  <= cfg_wdata_i;
        fpq_alu_pkg::CFG_HIGH_LIMIT: high_lim_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage takes data when empty or when it drains
  assign rdy[NSTG] = out_ready_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  // Prepare stage: results of the non-divide actions, multiply and divider setup
  always_comb begin
    logic signed [63:0] prod;
    logic signed [63:0] prod_sh;
    logic signed [DW-1:0] a_ext;
    logic signed [DW-1:0] a_shl;
    logic               lt;
    logic               gt;
    logic               eq;
    prod    = 64'(in_data_i.operand_a) * 64'(in_data_i.operand_b);
    prod_sh = prod >>> FRAC_BITS;
    a_ext   = DW'(in_data_i.operand_a);
    a_shl   = a_ext <<< FRAC_BITS;
    lt      = in_data_i.operand_a < in_data_i.operand_b;
    gt      = in_data_i.operand_a > in_data_i.operand_b;
    eq      = in_data_i.operand_a == in_data_i.operand_b;
    stg_d[0]        = '0;
    stg_d[0].action = in_data_i.action;
    stg_d[0].status = fpq_alu_pkg::ST_OK;
    stg_d[0].quo    = a_shl[DW-1] ? DW'(-a_shl) : DW'(a_shl);
    stg_d[0].dvs    = in_data_i.operand_b[31] ? 32'(-in_data_i.operand_b)
                                              : 32'(in_data_i.operand_b);
    stg_d[0].neg    = in_data_i.operand_a[31] ^ in_data_i.operand_b[31];
    case (in_data_i.action)
      fpq_alu_pkg::ACT_ADD: stg_d[0].res = in_data_i.operand_a + in_data_i.operand_b;
      fpq_alu_pkg::ACT_SUB: stg_d[0].res = in_data_i.operand_a - in_data_i.operand_b;
      fpq_alu_pkg::ACT_MUL: stg_d[0].res = prod_sh[31:0];
      fpq_alu_pkg::ACT_DIV: begin
        if (in_data_i.operand_b == 32'sd0) stg_d[0].status = fpq_alu_pkg::ST_DIV_ZERO;
      end
      fpq_alu_pkg::ACT_GT:  stg_d[0].cmp = gt;
      fpq_alu_pkg::ACT_LT:  stg_d[0].cmp = lt;
      fpq_alu_pkg::ACT_GE:  stg_d[0].cmp = !lt;
      fpq_alu_pkg::ACT_LE:  stg_d[0].cmp = !gt;
      fpq_alu_pkg::ACT_EQ:  stg_d[0].cmp = eq;
      fpq_alu_pkg::ACT_NE:  stg_d[0].cmp = !eq;
      fpq_alu_pkg::ACT_MIN: stg_d[0].res = lt ? in_data_i.operand_a : in_data_i.operand_b;
      fpq_alu_pkg::ACT_MAX: stg_d[0].res = gt ? in_data_i.operand_a : in_data_i.operand_b;
      fpq_alu_pkg::ACT_INC: stg_d[0].res = in_data_i.operand_a + 32'sd1;
      fpq_alu_pkg::ACT_DEC: stg_d[0].res = in_data_i.operand_a - 32'sd1;
      fpq_alu_pkg::ACT_FROM_INT: begin
        if (in_data_i.operand_a < low_lim_q ||
            33'(signed'(in_data_i.operand_a)) > $signed({2'b00, high_lim_q})) begin
          stg_d[0].status = fpq_alu_pkg::ST_RANGE;
        end else begin
          stg_d[0].res = a_shl[31:0];
        end
      end
      default: stg_d[0].res = 32'(in_data_i.operand_a >>> FRAC_BITS);
    endcase
  end

  // Divide stages: four restoring quotient bits per stage
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    always_comb begin
      logic [32:0] trial;
      stg_d[k] = stg_q[k-1];
      for (int s = 0; s < BPS; s++) begin
        if ((k - 1) * BPS + s < DW) begin
          stg_d[k].rem = {stg_d[k].rem[31:0], stg_d[k].quo[DW-1]};
          stg_d[k].quo = {stg_d[k].quo[DW-2:0], 1'b0};
          trial        = stg_d[k].rem - {1'b0, stg_d[k].dvs};
          if (!trial[32]) begin
            stg_d[k].rem    = trial;
            stg_d[k].quo[0] = 1'b1;
          end
        end
      end
    end
  end

  // Output stage: apply quotient sign and wrap to 32 bits
  always_comb begin
    stg_d[NSTG-1] = stg_q[NSTG-2];
    if (stg_q[NSTG-2].action == fpq_alu_pkg::ACT_DIV &&
        stg_q[NSTG-2].status == fpq_alu_pkg::ST_OK) begin
      stg_d[NSTG-1].res = stg_q[NSTG-2].neg ? 32'(-stg_q[NSTG-2].quo[31:0])
                                            : stg_q[NSTG-2].quo[31:0];
    end
  end

  // Advance stages
  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic vin;
    if (k == 0) begin : g_src_in
      assign vin = in_valid_i;
    end else begin : g_src_stg
      assign vin = vld_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_ready_o               = rdy[0];
  assign out_valid_o              = vld_q[NSTG-1];
  assign out_data_o.result_value  = stg_q[NSTG-1].res;
  assign out_data_o.compare_true  = stg_q[NSTG-1].cmp;
  assign out_data_o.status        = stg_q[NSTG-1].status;

  // Input stalls only when the output holds an untaken beat
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled with output free");

  // Divide by zero returns zero
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == fpq_alu_pkg::ST_DIV_ZERO)
      |-> out_data_o.result_value == 32'sd0)
    else $error("divide by zero with nonzero result");

  // Compare flag only set with ok status and zero value
  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.compare_true)
      |-> (out_data_o.status == fpq_alu_pkg::ST_OK && out_data_o.result_value == 32'sd0))
    else $error("compare flag with value or error");

endmodule

[test/tb_fixed_point_q24_8_alu_core.sv]
// ----------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu_core: self-checking bench for the Q24.8 ALU
// Drives directed and random request beats with random gaps and stalls,
// predicts every response in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int LATENCY = 12;
  localparam longint CYCLE_LIMIT = 200000;

  // Holds the conversion limits and the queue of pending responses
  class alu_scoreboard;
    logic signed [31:0] low_limit;
    logic [30:0] high_limit;
    fpq_alu_pkg::rsp_t pending_q[$];
    int errors;

    function new();
      low_limit = -32'sd8388608;
      high_limit = 31'd8388607;
      errors = 0;
    endfunction

    function void set_limit(fpq_alu_pkg::cfg_idx_e idx, logic [31:0] val);
      if (idx == fpq_alu_pkg::CFG_LOW_LIMIT) low_limit = val;
      else high_limit = val[30:0];
    endfunction

    // Compute the response for one accepted request beat
    function void note_request(fpq_alu_pkg::req_t rq);
      fpq_alu_pkg::rsp_t rs;
      logic signed [63:0] a, b, prod, num, quo;
      a = rq.operand_a;
      b = rq.operand_b;
      rs = '0;
      rs.status = fpq_alu_pkg::ST_OK;
      case (rq.action)
        fpq_alu_pkg::ACT_ADD: rs.result_value = rq.operand_a + rq.operand_b;
        fpq_alu_pkg::ACT_SUB: rs.result_value = rq.operand_a - rq.operand_b;
        fpq_alu_pkg::ACT_MUL: begin
          prod = a * b;
          prod = prod >>> FRAC;
          rs.result_value = prod[31:0];
        end
        fpq_alu_pkg::ACT_DIV: begin
          if (b == 0) rs.status = fpq_alu_pkg::ST_DIV_ZERO;
          else begin
            num = a <<< FRAC;
            quo = num / b;
            rs.result_value = quo[31:0];
          end
        end
        fpq_alu_pkg::ACT_GT: rs.compare_true = a > b;
        fpq_alu_pkg::ACT_LT: rs.compare_true = a < b;
        fpq_alu_pkg::ACT_GE: rs.compare_true = a >= b;
        fpq_alu_pkg::ACT_LE: rs.compare_true = a <= b;
        fpq_alu_pkg::ACT_EQ: rs.compare_true = a == b;
        fpq_alu_pkg::ACT_NE: rs.compare_true = a != b;
        fpq_alu_pkg::ACT_MIN: rs.result_value = (a < b) ? rq.operand_a : rq.operand_b;
        fpq_alu_pkg::ACT_MAX: rs.result_value = (a > b) ? rq.operand_a : rq.operand_b;
        fpq_alu_pkg::ACT_INC: rs.result_value = rq.operand_a + 32'sd1;
        fpq_alu_pkg::ACT_DEC: rs.result_value = rq.operand_a - 32'sd1;
        fpq_alu_pkg::ACT_FROM_INT: begin
          if (a < 64'(low_limit) || a > $signed({33'd0, high_limit}))
            rs.status = fpq_alu_pkg::ST_RANGE;
          else rs.result_value = rq.operand_a <<< FRAC;
        end
        default: rs.result_value = rq.operand_a >>> FRAC;
      endcase
      pending_q.push_back(rs);
    endfunction

    // Compare one response beat with the oldest prediction
    function void check_response(fpq_alu_pkg::rsp_t got);
      fpq_alu_pkg::rsp_t exp_rs;
      if (pending_q.size() == 0) begin
        $error("unexpected response beat %h", got);
        errors++;
        return;
      end
      exp_rs = pending_q.pop_front();
      if (got.result_value !== exp_rs.result_value) begin
        $error("result_value: expected %h actual %h", exp_rs.result_value, got.result_value);
        errors++;
      end
      if (got.compare_true !== exp_rs.compare_true) begin
        $error("compare_true: expected %b actual %b", exp_rs.compare_true, got.compare_true);
        errors++;
      end
      if (got.status !== exp_rs.status) begin
        $error("status: expected %0d actual %0d", exp_rs.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  fpq_alu_pkg::req_t in_data;
  fpq_alu_pkg::rsp_t out_data;
  logic cfg_we;
  fpq_alu_pkg::cfg_idx_e cfg_idx;
  logic [31:0] cfg_wdata;
  longint cycles;
  alu_scoreboard sb;

  fixed_point_q24_8_alu_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_point_q24_8_alu_core: mismatch");
      $finish;
    end
  end

  // Check response beats and, after some of them, draw a random stall
  int stall_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_response(out_data);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        if ($urandom_range(3) == 0) begin
          stall_left <= $urandom_range(17);
          out_ready <= 1'b0;
        end else out_ready <= 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  // Write the low and then the high conversion limit
  task automatic write_limits(logic [31:0] low_val, logic [31:0] high_val);
    cfg_we <= 1'b1;
    cfg_idx <= fpq_alu_pkg::CFG_LOW_LIMIT;
    cfg_wdata <= low_val;
    @(posedge clk);
    sb.set_limit(fpq_alu_pkg::CFG_LOW_LIMIT, low_val);
    cfg_idx <= fpq_alu_pkg::CFG_HIGH_LIMIT;
    cfg_wdata <= high_val;
    @(posedge clk);
    sb.set_limit(fpq_alu_pkg::CFG_HIGH_LIMIT, high_val);
    cfg_we <= 1'b0;
  endtask

  // Send one request beat after an optional gap; valid stays high for the next one
  task automatic send_beat(fpq_alu_pkg::action_e act, logic [31:0] a, logic [31:0] b,
                           int gap);
    fpq_alu_pkg::req_t rq;
    rq.action = act;
    rq.operand_a = a;
    rq.operand_b = b;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return 32'($signed($urandom_range(2048)) - 1024);
      3: return 32'($signed($urandom_range(16)) - 8) <<< FRAC;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count, logic bursty);
    fpq_alu_pkg::action_e act;
    logic [31:0] a, b;
    for (int n = 0; n < count; n++) begin
      act = fpq_alu_pkg::action_e'($urandom_range(15));
      a = pick_operand();
      b = ($urandom_range(7) == 0) ? a : pick_operand();
      if (act == fpq_alu_pkg::ACT_DIV && $urandom_range(7) == 0) b = '0;
      if (act == fpq_alu_pkg::ACT_FROM_INT && $urandom_range(1) == 0)
        a = 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
      send_beat(act, a, b, bursty ? 0 : (($urandom_range(2) == 0) ? $urandom_range(17) : 0));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = fpq_alu_pkg::CFG_LOW_LIMIT;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every action, operand extremes and the special cases
    send_beat(fpq_alu_pkg::ACT_ADD, 32'h7fff_ffff, 32'd1, 0);
    send_beat(fpq_alu_pkg::ACT_SUB, 32'h8000_0000, 32'd1, 0);
    send_beat(fpq_alu_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    send_beat(fpq_alu_pkg::ACT_MUL, 32'hffff_ff00, 32'h0000_0180, 0);
    send_beat(fpq_alu_pkg::ACT_DIV, 32'h0000_0100, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_DIV, 32'h7fff_ffff, 32'd1, 0);
    send_beat(fpq_alu_pkg::ACT_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_DIV, 32'hffff_fd00, 32'h0000_0200, 0);
    send_beat(fpq_alu_pkg::ACT_GT, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_LT, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_GE, 32'd5, 32'd5, 0);
    send_beat(fpq_alu_pkg::ACT_LE, 32'd6, 32'd5, 0);
    send_beat(fpq_alu_pkg::ACT_EQ, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_NE, 32'd0, 32'hffff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_MIN, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_MAX, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_INC, 32'h7fff_ffff, 32'hffff_ffff, 0);
    send_beat(fpq_alu_pkg::ACT_DEC, 32'h8000_0000, 32'h1234_5678, 0);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'h007f_ffff, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'h0080_0000, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'hff80_0000, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'hff7f_ffff, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_TO_INT, 32'hffff_ff01, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_TO_INT, 32'h7fff_ffff, 32'd0, 0);
    drain();

    // Random phases across limit settings, extremes and crossed limits included
    random_phase(250, 1'b0);
    drain();
    write_limits(32'h8000_0000, 32'h7fff_ffff);
    random_phase(200, 1'b1);
    drain();
    write_limits(32'd0, 32'd0);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'd0, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'd1, 32'd0, 0);
    random_phase(150, 1'b0);
    drain();
    write_limits(32'h0000_0100, 32'h0000_00ff);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'h0000_0100, 32'd0, 0);
    send_beat(fpq_alu_pkg::ACT_FROM_INT, 32'h0000_00ff, 32'd0, 0);
    drain();
    write_limits(32'hffff_f000, 32'h0000_4000);
    random_phase(200, 1'b0);
    drain();
    write_limits(32'h8000_0000, 32'hffff_ffff);
    random_phase(200, 1'b0);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("fixed_point_q24_8_alu_core: match");
    else
      $display("fixed_point_q24_8_alu_core: mismatch");
    $finish;
  end
endmodule
